FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the culling block modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: rtl/cscull_pkg.sv
// ----------------------------------------------------------------------------
// cscull_pkg
// Constants and types shared by the clip-space box culling modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cscull_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_PLANES  = 6;
    localparam int ROW_W       = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_AW      = 1;

    localparam int PROD_W      = 2 * COORD_WIDTH;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int CLIP_W      = PROD_W + 2;
    localparam int TEST_W      = PROD_W + 3;

    localparam logic [NUM_PLANES-1:0] ALL_PLANES = '1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [PAIR_W-1:0]      t_pair;
    typedef logic signed [CLIP_W-1:0]      t_clip;
    typedef logic signed [TEST_W-1:0]      t_test;

    typedef enum logic {
        OP_ROW_LOAD = 1'b0,
        OP_CORNER   = 1'b1
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [ROW_W-1:0]       row_index;
        logic                   last_corner;
        logic                   object_culling;
        t_coord [NUM_COLS-1:0]  data;
    } t_item;

endpackage

`default_nettype wire

FILE: rtl/cscull_front.sv
// ----------------------------------------------------------------------------
// cscull_front
// Accepts items, sorts them into row loads and corners, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cscull_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    output logic                                  o_full,
    input  wire logic                             i_req_type,
    input  wire logic [cscull_pkg::ROW_W-1:0]     i_row_index,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_coef_0,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_coef_1,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_coef_2,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_coef_3,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_point_z,
    input  wire logic                             i_last_corner,
    input  wire logic                             i_object_culling,
    output logic                                  o_item_valid,
    output cscull_pkg::t_item                     o_item,
    input  wire logic                             i_item_ready
);

    cscull_pkg::t_item               r_queue [cscull_pkg::QUEUE_DEPTH];
    logic [cscull_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [cscull_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [cscull_pkg::QUEUE_AW:0]   r_count;
    logic [cscull_pkg::QUEUE_AW:0]   n_count;
    cscull_pkg::t_item               n_item;
    logic                            w_push;
    logic                            w_pop;

    always_comb begin
        n_item                = '0;
        n_item.row_index      = i_row_index;
        n_item.last_corner    = i_last_corner;
        n_item.object_culling = i_object_culling;
        if (i_req_type) begin
            n_item.op      = cscull_pkg::OP_CORNER;
            n_item.data[0] = i_point_x;
            n_item.data[1] = i_point_y;
            n_item.data[2] = i_point_z;
            n_item.data[3] = '0;
        end else begin
            n_item.op      = cscull_pkg::OP_ROW_LOAD;
            n_item.data[0] = i_coef_0;
            n_item.data[1] = i_coef_1;
            n_item.data[2] = i_coef_2;
            n_item.data[3] = i_coef_3;
        end
    end

    assign o_full       = (r_count == (cscull_pkg::QUEUE_AW+1)'(cscull_pkg::QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_queue[r_rd_ptr];
    assign w_push       = i_push && !o_full;
    assign w_pop        = o_item_valid && i_item_ready;

    always_comb begin
        n_count = r_count;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + (cscull_pkg::QUEUE_AW+1)'(1);
            2'b01:   n_count = r_count - (cscull_pkg::QUEUE_AW+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + cscull_pkg::QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + cscull_pkg::QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= n_item;
        end
    end

    `ASSERT_NEVER(a_queue_over, i_clk, i_rst_n, r_count > cscull_pkg::QUEUE_DEPTH)
    `ASSERT_CLK(a_queue_fill, i_clk, i_rst_n, (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))

endmodule

`default_nettype wire

FILE: rtl/cscull_back.sv
// ----------------------------------------------------------------------------
// cscull_back
// Holds the clip matrix, transforms corners, tests planes, queues results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cscull_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    input  wire cscull_pkg::t_item i_item,
    output logic                   o_item_ready,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic                   o_culled
);

    cscull_pkg::t_coord r_matrix [cscull_pkg::NUM_ROWS][cscull_pkg::NUM_COLS];

    logic                r_enable;
    logic [cscull_pkg::NUM_PLANES-1:0] r_seen;

    logic                r_s1_valid;
    logic                r_s1_last;
    logic                r_s1_obj;
    cscull_pkg::t_prod   r_s1_prod  [cscull_pkg::NUM_ROWS][cscull_pkg::NUM_AXES];
    cscull_pkg::t_prod   r_s1_const [cscull_pkg::NUM_ROWS];
    cscull_pkg::t_prod   n_s1_prod  [cscull_pkg::NUM_ROWS][cscull_pkg::NUM_AXES];
    cscull_pkg::t_prod   n_s1_const [cscull_pkg::NUM_ROWS];
    logic                n_s1_valid;

    logic                r_s2_valid;
    logic                r_s2_last;
    logic                r_s2_obj;
    cscull_pkg::t_pair   r_s2_a [cscull_pkg::NUM_ROWS];
    cscull_pkg::t_pair   r_s2_b [cscull_pkg::NUM_ROWS];

    logic                r_s3_valid;
    logic                r_s3_last;
    logic                r_s3_obj;
    cscull_pkg::t_clip   r_s3_clip [cscull_pkg::NUM_ROWS];

    logic [cscull_pkg::NUM_PLANES-1:0] w_flags;
    logic [cscull_pkg::NUM_PLANES-1:0] w_seen_all;
    logic                w_result;
    logic                w_adv;
    logic                w_row_load;

    logic                r_out_data [cscull_pkg::OUT_DEPTH];
    logic [cscull_pkg::OUT_AW-1:0] r_out_wr;
    logic [cscull_pkg::OUT_AW-1:0] r_out_rd;
    logic [cscull_pkg::OUT_AW:0]   r_out_cnt;
    logic [cscull_pkg::OUT_AW:0]   n_out_cnt;
    logic                w_out_full;
    logic                w_out_push;
    logic                w_out_pop;

    assign w_out_full   = (r_out_cnt == (cscull_pkg::OUT_AW+1)'(cscull_pkg::OUT_DEPTH));
    assign w_adv        = !(r_s3_valid && r_s3_last && w_out_full);
    assign o_item_ready = w_adv;
    assign w_row_load   = i_item_valid && (i_item.op == cscull_pkg::OP_ROW_LOAD);
    assign n_s1_valid   = i_item_valid && (i_item.op == cscull_pkg::OP_CORNER);

    always_ff @(posedge i_clk) begin
        if (w_adv && w_row_load) begin
            for (int c = 0; c < cscull_pkg::NUM_COLS; c++) begin
                r_matrix[i_item.row_index][c] <= $signed(i_item.data[c]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < cscull_pkg::NUM_ROWS; r++) begin
            for (int a = 0; a < cscull_pkg::NUM_AXES; a++) begin
                n_s1_prod[r][a] = r_matrix[r][a] * $signed(i_item.data[a]);
            end
            n_s1_const[r] = cscull_pkg::t_prod'(r_matrix[r][cscull_pkg::NUM_COLS-1])
                            <<< cscull_pkg::FRAC_BITS;
        end
    end

    always_comb begin
        for (int k = 0; k < cscull_pkg::NUM_AXES; k++) begin
            cscull_pkg::t_test t_plus;
            cscull_pkg::t_test t_minus;
            t_plus  = cscull_pkg::t_test'(r_s3_clip[cscull_pkg::NUM_ROWS-1])
                      + cscull_pkg::t_test'(r_s3_clip[k]);
            t_minus = cscull_pkg::t_test'(r_s3_clip[cscull_pkg::NUM_ROWS-1])
                      - cscull_pkg::t_test'(r_s3_clip[k]);
            w_flags[2*k]   = (t_plus > 0);
            w_flags[2*k+1] = (t_minus > 0);
        end
    end

    assign w_seen_all = r_seen | w_flags;
    assign w_result   = r_enable && r_s3_obj && (w_seen_all != cscull_pkg::ALL_PLANES);
    assign w_out_push = r_s3_valid && r_s3_last && w_adv;
    assign w_out_pop  = i_pop && !o_empty;
    assign o_empty    = (r_out_cnt == '0);
    assign o_culled   = r_out_data[r_out_rd];

    always_comb begin
        n_out_cnt = r_out_cnt;
        case ({w_out_push, w_out_pop})
            2'b10:   n_out_cnt = r_out_cnt + (cscull_pkg::OUT_AW+1)'(1);
            2'b01:   n_out_cnt = r_out_cnt - (cscull_pkg::OUT_AW+1)'(1);
            default: n_out_cnt = r_out_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_seen     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_out_wr   <= '0;
            r_out_rd   <= '0;
            r_out_cnt  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (w_adv) begin
                r_s1_valid <= n_s1_valid;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
                if (r_s3_valid) begin
                    r_seen <= r_s3_last ? '0 : w_seen_all;
                end
            end
            if (w_out_push) begin
                r_out_wr <= r_out_wr + cscull_pkg::OUT_AW'(1);
            end
            if (w_out_pop) begin
                r_out_rd <= r_out_rd + cscull_pkg::OUT_AW'(1);
            end
            r_out_cnt <= n_out_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_last <= i_item.last_corner;
            r_s1_obj  <= i_item.object_culling;
            r_s2_last <= r_s1_last;
            r_s2_obj  <= r_s1_obj;
            r_s3_last <= r_s2_last;
            r_s3_obj  <= r_s2_obj;
            for (int r = 0; r < cscull_pkg::NUM_ROWS; r++) begin
                r_s1_const[r] <= n_s1_const[r];
                for (int a = 0; a < cscull_pkg::NUM_AXES; a++) begin
                    r_s1_prod[r][a] <= n_s1_prod[r][a];
                end
                r_s2_a[r]    <= cscull_pkg::t_pair'(r_s1_prod[r][0])
                                + cscull_pkg::t_pair'(r_s1_prod[r][1]);
                r_s2_b[r]    <= cscull_pkg::t_pair'(r_s1_prod[r][2])
                                + cscull_pkg::t_pair'(r_s1_const[r]);
                r_s3_clip[r] <= cscull_pkg::t_clip'(r_s2_a[r])
                                + cscull_pkg::t_clip'(r_s2_b[r]);
            end
        end
        if (w_out_push) begin
            r_out_data[r_out_wr] <= w_result;
        end
    end

    `ASSERT_NEVER(a_out_overflow, i_clk, i_rst_n, w_out_push && w_out_full)
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, (r_s3_valid && !w_adv) |=> (r_s3_valid && $stable(r_seen)))

endmodule

`default_nettype wire

FILE: rtl/clip_space_box_frustum_cull.sv
// ----------------------------------------------------------------------------
// clip_space_box_frustum_cull
// Clip-space bounding-box frustum culling, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel: present an item with push high; it is taken at a rising edge
// where full is low. A row-load item (req_type 0) writes one matrix row and
// gives no result. A corner item (req_type 1) is transformed and tested; the
// corner marked last_corner gives one result on the output channel.
// Output channel: while empty is low the oldest result is on o_culled; pop
// high at a rising edge takes it.
// A last corner passes the input queue, transform pipeline and result queue.
// Throughput: one item per cycle unless the pipeline holds; its steps are
// multiply, pair add, final add and plane compare, with twelve 32x32 products.
// Configuration: i_cfg_wr_en writes culling_enable from i_cfg_wr_data.
// Reset: queues empty, plane flags clear, culling enabled; the matrix must be
// loaded before corners arrive.
// Receiver stall: results queue two deep, then the pipeline holds and the
// input queue fills until full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module clip_space_box_frustum_cull (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      push,
    output logic                                           full,
    input  wire logic                                      i_req_type,
    input  wire logic [cscull_pkg::ROW_W-1:0]              i_row_index,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_coef_0,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_coef_1,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_coef_2,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_coef_3,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [cscull_pkg::COORD_WIDTH-1:0] i_point_z,
    input  wire logic                                      i_last_corner,
    input  wire logic                                      i_object_culling,
    output logic                                           empty,
    input  wire logic                                      pop,
    output logic                                           o_culled,
    input  wire logic                                      i_cfg_wr_en,
    input  wire logic                                      i_cfg_wr_data
);

    logic              w_item_valid;
    logic              w_item_ready;
    cscull_pkg::t_item w_item;

    cscull_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_req_type       (i_req_type),
        .i_row_index      (i_row_index),
        .i_coef_0         (i_coef_0),
        .i_coef_1         (i_coef_1),
        .i_coef_2         (i_coef_2),
        .i_coef_3         (i_coef_3),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_point_z        (i_point_z),
        .i_last_corner    (i_last_corner),
        .i_object_culling (i_object_culling),
        .o_item_valid     (w_item_valid),
        .o_item           (w_item),
        .i_item_ready     (w_item_ready)
    );

    cscull_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .i_item        (w_item),
        .o_item_ready  (w_item_ready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_culled      (o_culled)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for clip_space_box_frustum_cull. Loads clip matrices,
// streams box corners through the push/full queue port and pops culled flags
// from the empty/pop side. Each accepted item is run through an in-bench
// model of the six-plane clip test; results are checked in order. A short
// directed table comes first, then random boxes, matrix reloads and noise
// under random idling on both sides, a back-pressure burst and changes of
// the scene-wide culling switch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cscull_pkg::*;

    localparam int     Q1            = 65536;
    localparam t_coord Q_ONE         = 32'sh0001_0000;
    localparam t_coord Q_TWO         = 32'sh0002_0000;
    localparam t_coord Q_MAX         = 32'sh7fff_ffff;
    localparam t_coord Q_MIN         = 32'sh8000_0000;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     CYCLE_LIMIT   = 300000;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_CLEAR,
        CHK_CULLED
    } t_culled_check;

    typedef struct packed {
        t_op              op;
        logic [ROW_W-1:0] row;
        t_coord           c0;
        t_coord           c1;
        t_coord           c2;
        t_coord           c3;
        t_coord           px;
        t_coord           py;
        t_coord           pz;
        logic             last;
        logic             obj_cull;
        t_culled_check    check;
    } t_cull_req;

    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             push             = 1'b0;
    logic             full;
    logic             i_req_type       = 1'b0;
    logic [ROW_W-1:0] i_row_index      = '0;
    t_coord           i_coef_0         = '0;
    t_coord           i_coef_1         = '0;
    t_coord           i_coef_2         = '0;
    t_coord           i_coef_3         = '0;
    t_coord           i_point_x        = '0;
    t_coord           i_point_y        = '0;
    t_coord           i_point_z        = '0;
    logic             i_last_corner    = 1'b0;
    logic             i_object_culling = 1'b0;
    logic             empty;
    logic             pop              = 1'b0;
    logic             o_culled;
    logic             i_cfg_wr_en      = 1'b0;
    logic             i_cfg_wr_data    = 1'b0;

    t_coord              clip_m [NUM_ROWS][NUM_COLS];
    logic [NUM_PLANES-1:0] planes_seen = '0;
    bit                  culling_on  = 1'b1;
    bit                  culled_expected [$];
    int unsigned         mismatches  = 0;
    int unsigned         cycle_count = 0;
    bit                  src_gaps_on = 1'b1;
    bit                  snk_gaps_on = 1'b1;
    bit                  hold_request = 1'b0;

    clip_space_box_frustum_cull dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_req_type       (i_req_type),
        .i_row_index      (i_row_index),
        .i_coef_0         (i_coef_0),
        .i_coef_1         (i_coef_1),
        .i_coef_2         (i_coef_2),
        .i_coef_3         (i_coef_3),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_point_z        (i_point_z),
        .i_last_corner    (i_last_corner),
        .i_object_culling (i_object_culling),
        .empty            (empty),
        .pop              (pop),
        .o_culled         (o_culled),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[cycle %0d] %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic t_cull_req mk_row(input logic [ROW_W-1:0] row,
                                         input t_coord c0, input t_coord c1,
                                         input t_coord c2, input t_coord c3);
        t_cull_req r;
        r = '0;
        r.op  = OP_ROW_LOAD;
        r.row = row;
        r.c0  = c0;
        r.c1  = c1;
        r.c2  = c2;
        r.c3  = c3;
        r.check = CHK_PREDICT;
        return r;
    endfunction

    function automatic t_cull_req mk_corner(input t_coord x, input t_coord y,
                                            input t_coord z, input logic last,
                                            input logic oc, input t_culled_check chk);
        t_cull_req r;
        r = '0;
        r.op       = OP_CORNER;
        r.px       = x;
        r.py       = y;
        r.pz       = z;
        r.last     = last;
        r.obj_cull = oc;
        r.check    = chk;
        return r;
    endfunction

    function automatic t_coord rand_q(input int span);
        return t_coord'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_coord rand_wild();
        case ($urandom_range(0, 5))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return rand_q(4 * Q1);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Six plane flags of one corner: bit 2k is -w<c, bit 2k+1 is c<w.
    function automatic logic [NUM_PLANES-1:0] corner_planes(input t_coord x, input t_coord y,
                                                            input t_coord z);
        logic signed [127:0]   clip_v [NUM_ROWS];
        logic signed [127:0]   a;
        logic signed [127:0]   p;
        t_coord                pt [NUM_AXES];
        logic [NUM_PLANES-1:0] f;
        int                    r;
        int                    c;
        pt[0] = x;
        pt[1] = y;
        pt[2] = z;
        f = '0;
        for (r = 0; r < NUM_ROWS; r++) begin
            a = clip_m[r][3];
            clip_v[r] = a <<< FRAC_BITS;
            for (c = 0; c < NUM_AXES; c++) begin
                a = clip_m[r][c];
                p = pt[c];
                clip_v[r] = clip_v[r] + a * p;
            end
        end
        for (c = 0; c < NUM_AXES; c++) begin
            if (clip_v[c] + clip_v[3] > 0)
                f[2 * c] = 1'b1;
            if (clip_v[3] - clip_v[c] > 0)
                f[2 * c + 1] = 1'b1;
        end
        return f;
    endfunction

    task automatic predict_cull(input t_cull_req r);
        bit c;
        if (r.op == OP_ROW_LOAD) begin
            clip_m[r.row][0] = r.c0;
            clip_m[r.row][1] = r.c1;
            clip_m[r.row][2] = r.c2;
            clip_m[r.row][3] = r.c3;
        end else begin
            planes_seen = planes_seen | corner_planes(r.px, r.py, r.pz);
            if (r.last) begin
                c = culling_on && r.obj_cull && (planes_seen != ALL_PLANES);
                planes_seen = '0;
                case (r.check)
                    CHK_CLEAR:  culled_expected.insert(culled_expected.size(), 1'b0);
                    CHK_CULLED: culled_expected.insert(culled_expected.size(), 1'b1);
                    default:    culled_expected.insert(culled_expected.size(), c);
                endcase
            end
        end
    endtask

    task automatic send_req(input t_cull_req r);
        int unsigned gap;
        gap = src_gaps_on ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_req_type       <= r.op;
        i_row_index      <= r.row;
        i_coef_0         <= r.c0;
        i_coef_1         <= r.c1;
        i_coef_2         <= r.c2;
        i_coef_3         <= r.c3;
        i_point_x        <= r.px;
        i_point_y        <= r.py;
        i_point_z        <= r.pz;
        i_last_corner    <= r.last;
        i_object_culling <= r.obj_cull;
        do @(posedge i_clk); while (full);
        predict_cull(r);
    endtask

    function automatic t_cull_req random_row(input logic [ROW_W-1:0] row);
        t_cull_req r;
        t_coord    diag;
        int unsigned style;
        style = $urandom_range(0, 3);
        diag  = t_coord'($urandom_range(Q1 / 4, 2 * Q1));
        r = mk_row(row, rand_q(Q1 / 2), rand_q(Q1 / 2), rand_q(Q1 / 2), rand_q(Q1 / 2));
        if (style < 2) begin
            case (row)
                2'd0: r.c0 = diag;
                2'd1: r.c1 = diag;
                2'd2: r.c2 = diag;
                default: begin
                    r.c0 = rand_q(Q1 / 8);
                    r.c1 = rand_q(Q1 / 8);
                    r.c2 = rand_q(Q1 / 8);
                    r.c3 = diag;
                end
            endcase
        end else if (style == 2) begin
            r = mk_row(row, rand_q(2 * Q1), rand_q(2 * Q1), rand_q(2 * Q1), rand_q(2 * Q1));
        end else begin
            r = mk_row(row, rand_wild(), rand_wild(), rand_wild(), rand_wild());
        end
        r.px       = t_coord'($urandom);
        r.py       = t_coord'($urandom);
        r.pz       = t_coord'($urandom);
        r.last     = $urandom_range(0, 1);
        r.obj_cull = $urandom_range(0, 1);
        return r;
    endfunction

    task automatic send_box(input int nc);
        t_coord    cx;
        t_coord    cy;
        t_coord    cz;
        t_coord    h;
        logic      oc;
        bit        wild;
        t_cull_req r;
        int        i;
        cx   = rand_q(3 * Q1);
        cy   = rand_q(3 * Q1);
        cz   = rand_q(3 * Q1);
        h    = t_coord'($urandom_range(0, Q1));
        wild = ($urandom_range(0, 7) == 0);
        oc   = ($urandom_range(0, 7) != 0);
        for (i = 0; i < nc; i++) begin
            if (wild)
                r = mk_corner(rand_wild(), rand_wild(), rand_wild(), i == nc - 1, oc,
                              CHK_PREDICT);
            else
                r = mk_corner(i[0] ? cx + h : cx - h, i[1] ? cy + h : cy - h,
                              i[2] ? cz + h : cz - h, i == nc - 1, oc, CHK_PREDICT);
            r.row = $urandom_range(0, 3);
            r.c0  = t_coord'($urandom);
            r.c1  = t_coord'($urandom);
            r.c2  = t_coord'($urandom);
            r.c3  = t_coord'($urandom);
            send_req(r);
        end
    endtask

    task automatic run_random(input int n_items);
        int          sent;
        int          nc;
        int unsigned kind;
        int          r;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                for (r = 0; r < NUM_ROWS; r++)
                    send_req(random_row(r));
                sent += NUM_ROWS;
            end else if (kind == 1) begin
                send_req(random_row($urandom_range(0, 3)));
                sent++;
            end else if (kind == 2) begin
                send_req(mk_corner(rand_wild(), rand_wild(), rand_wild(),
                                   $urandom_range(0, 1), $urandom_range(0, 1), CHK_PREDICT));
                sent++;
            end else begin
                nc = ($urandom_range(0, 9) < 7) ? 8 : $urandom_range(1, 7);
                send_box(nc);
                sent += nc;
            end
        end
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        while (culled_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_culling(input bit on);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= on;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        culling_on = on;
    endtask

    initial begin : result_sink
        int unsigned stall;
        bit          wanted;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = snk_gaps_on ? $urandom_range(0, 13) : 0;
            end
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (culled_expected.size() == 0) begin
                report_mismatch($sformatf("culled=%0b popped with no result pending", o_culled));
            end else begin
                wanted = culled_expected.pop_front();
                if (o_culled !== wanted)
                    report_mismatch($sformatf("culled=%0b, predicted %0b", o_culled, wanted));
            end
        end
    end

    initial begin : stimulus
        t_cull_req dir_tab [$];
        int        i;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity matrix, then boxes whose verdict is plain
        dir_tab.insert(dir_tab.size(), mk_row(2'd0, Q_ONE, 0, 0, 0));
        dir_tab.insert(dir_tab.size(), mk_row(2'd1, 0, Q_ONE, 0, 0));
        dir_tab.insert(dir_tab.size(), mk_row(2'd2, 0, 0, Q_ONE, 0));
        dir_tab.insert(dir_tab.size(), mk_row(2'd3, 0, 0, 0, Q_ONE));
        dir_tab.insert(dir_tab.size(), mk_corner(0, 0, 0, 1'b1, 1'b1, CHK_CLEAR));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_TWO, 0, 0, 1'b1, 1'b1, CHK_CULLED));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_TWO, 0, 0, 1'b1, 1'b0, CHK_CLEAR));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_TWO, 0, 0, 1'b0, 1'b1, CHK_PREDICT));
        dir_tab.insert(dir_tab.size(), mk_corner(-Q_TWO, 0, 0, 1'b1, 1'b1, CHK_CLEAR));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_ONE, 0, 0, 1'b1, 1'b1, CHK_CULLED));
        dir_tab.insert(dir_tab.size(), mk_corner(0, 0, -Q_ONE, 1'b1, 1'b1, CHK_CULLED));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_MAX, Q_MIN, Q_MAX, 1'b1, 1'b1, CHK_CULLED));
        dir_tab.insert(dir_tab.size(), mk_corner(0, Q_TWO, 0, 1'b0, 1'b1, CHK_PREDICT));
        dir_tab.insert(dir_tab.size(), mk_corner(0, 0, 0, 1'b1, 1'b1, CHK_CLEAR));
        // extreme coefficients
        dir_tab.insert(dir_tab.size(), mk_row(2'd3, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        dir_tab.insert(dir_tab.size(), mk_row(2'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b1, CHK_PREDICT));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b1, CHK_PREDICT));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_MIN, Q_MAX, 0, 1'b1, 1'b1, CHK_PREDICT));
        dir_tab.insert(dir_tab.size(), mk_row(2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        dir_tab.insert(dir_tab.size(), mk_corner(Q_MAX, Q_MIN, Q_MAX, 1'b1, 1'b1, CHK_PREDICT));

        set_culling(1'b1);
        for (i = 0; i < dir_tab.size(); i++)
            send_req(dir_tab[i]);
        push <= 1'b0;

        set_culling(1'b0);
        run_random(120);
        set_culling(1'b1);
        run_random(200);

        // hold the result side while a burst of single-corner boxes fills the queues
        wait_drained();
        src_gaps_on  = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_box(1);
        push <= 1'b0;
        wait_drained();

        snk_gaps_on = 1'b0;
        run_random(180);
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        set_culling(1'b0);
        run_random(60);
        set_culling(1'b1);
        run_random(100);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
